// ===== src/sha256_pkg.sv =====
//------------------------------------------------------------------------------
// SHA-256 package
// Shared types, round constants and round functions of the hash engine.
//------------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // commands from controller to datapath
   typedef struct packed {
      logic absorb;      // write the request byte into the block buffer
      logic pad_80;      // write 0x80 at the fill position
      logic zero_fill;   // clear one byte at the fill position
      logic len_write;   // write one length byte at the fill position
      logic round_start; // load working variables and schedule
      logic round_step;  // run one compression round
      logic hash_add;    // fold working variables into the hash
      logic restart;     // return to initial hash and empty buffer
   } sha_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [5:0] fill;
      logic       round_last;
      logic       load_done;
   } sha_stat_type;

   localparam logic [7:0] PadByte  = 8'h80;
   localparam logic [5:0] LenStart = 6'd56;

   localparam logic [31:0] InitH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] x);
      small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] x);
      small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

`default_nettype wire

// ===== src/sha256_ram.sv =====
//------------------------------------------------------------------------------
// SHA-256 generic RAM
// Single write port, single read port with registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module sha256_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output      logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== src/sha256_datapath.sv =====
//------------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer RAM, length counter, schedule window, working variables, hash.
//------------------------------------------------------------------------------
`default_nettype none

module sha256_datapath (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire sha256_pkg::sha_cmd_type  cmd,
   input  wire logic [7:0]               in_byte,
   input  wire logic [2:0]               out_sel,
   output      sha256_pkg::sha_stat_type stat,
   output      logic [31:0]              out_word
);
   import sha256_pkg::*;

   logic [5:0]  fill_ff, fill_in;
   logic [63:0] len_ff, len_in;
   logic [2:0]  len_idx_ff, len_idx_in;
   logic [31:0] h_ff [8];
   logic [31:0] v_ff [8];
   logic [31:0] w_ff [16];
   logic [5:0]  rnd_ff, rnd_in;
   logic [6:0]  ld_ff, ld_in;    // load counter: 64 buffer reads, then the last registered read data
   logic        loading_ff, loading_in;
   logic        wr_en;
   logic [7:0]  wr_data;
   logic [7:0]  rd_data;
   logic [31:0] w_new, t1, t2, w_cur;

   // select the byte written into the buffer
   always_comb begin
      wr_en   = cmd.absorb | cmd.pad_80 | cmd.zero_fill | cmd.len_write;
      wr_data = 8'd0;
      priority if (cmd.absorb) begin
         wr_data = in_byte;
      end else if (cmd.pad_80) begin
         wr_data = PadByte;
      end else if (cmd.len_write) begin
         wr_data = len_ff[8*(7 - 32'(len_idx_ff)) +: 8];
      end
   end

   sha256_ram #(.Width(8), .Depth(64)) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff),
      .wr_data (wr_data),
      .rd_addr (ld_ff[5:0]),
      .rd_data (rd_data)
   );

   // advance fill position, length and length byte index
   always_comb begin
      fill_in    = fill_ff;
      len_in     = len_ff;
      len_idx_in = len_idx_ff;
      if (wr_en) begin
         fill_in = fill_ff + 6'd1;
      end
      if (cmd.absorb) begin
         len_in = len_ff + 64'd8;
      end
      if (cmd.len_write) begin
         len_idx_in = len_idx_ff + 3'd1;
      end
      if (cmd.restart) begin
         fill_in    = 6'd0;
         len_in     = 64'd0;
         len_idx_in = 3'd0;
      end
   end

   // sequence buffer loading and rounds
   always_comb begin
      ld_in      = ld_ff;
      loading_in = loading_ff;
      rnd_in     = rnd_ff;
      if (cmd.round_start) begin
         ld_in      = 7'd0;
         loading_in = 1'b1;
         rnd_in     = 6'd0;
      end else if (loading_ff) begin
         ld_in = ld_ff + 7'd1;
         if (ld_ff == 7'd64) begin
            loading_in = 1'b0;
         end
      end
      if (cmd.round_step) begin
         rnd_in = rnd_ff + 6'd1;
      end
   end

   // schedule word and round terms
   always_comb begin
      w_new = small_sig1(w_ff[14]) + w_ff[9] + small_sig0(w_ff[1]) + w_ff[0];
      w_cur = (rnd_ff < 6'd16) ? w_ff[0] : w_new;
      t1 = v_ff[7] + big_sig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + RoundK[rnd_ff] + w_cur;
      t2 = big_sig0(v_ff[0])
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= 6'd0;
         len_ff     <= 64'd0;
         len_idx_ff <= 3'd0;
         ld_ff      <= 7'd0;
         loading_ff <= 1'b0;
         rnd_ff     <= 6'd0;
      end else begin
         fill_ff    <= fill_in;
         len_ff     <= len_in;
         len_idx_ff <= len_idx_in;
         ld_ff      <= ld_in;
         loading_ff <= loading_in;
         rnd_ff     <= rnd_in;
      end
   end

   // hash words, working variables and schedule window
   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= InitH[i];
         end
      end else if (cmd.hash_add) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= h_ff[i] + v_ff[i];
         end
      end
      if (cmd.round_start) begin
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= h_ff[i];
         end
      end else if (cmd.round_step) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
      // shift bytes in while loading, words out while rounding
      if (loading_ff && ld_ff != 7'd0) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= {w_ff[i][23:0], w_ff[i+1][31:24]};
         end
         w_ff[15] <= {w_ff[15][23:0], rd_data};
      end else if (cmd.round_step) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= w_cur;
      end
   end

   assign stat.fill       = fill_ff;
   assign stat.round_last = (rnd_ff == 6'd63);
   assign stat.load_done  = ~loading_ff;
   assign out_word        = h_ff[out_sel];

endmodule

`default_nettype wire

// ===== src/sha256_ctrl.sv =====
//------------------------------------------------------------------------------
// SHA-256 controller
// Handshakes, padding sequence, block compression and digest output.
//------------------------------------------------------------------------------
`default_nettype none

module sha256_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   input  wire sha256_pkg::req_type      req_data,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      logic [2:0]               out_sel,
   input  wire sha256_pkg::sha_stat_type stat,
   output      sha256_pkg::sha_cmd_type  cmd
);
   import sha256_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_END   = 9'b000000010,
      ST_PAD   = 9'b000000100,
      ST_ZERO  = 9'b000001000,
      ST_LEN   = 9'b000010000,
      ST_LOAD  = 9'b000100000,
      ST_ROUND = 9'b001000000,
      ST_ADD   = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   state_type  state_ff, state_in;
   logic       final_ff, final_in;   // block being hashed is the last one
   logic       pend_ff, pend_in;     // end marker still to process
   logic       tail_ff, tail_in;     // padding under way, length not yet written
   logic [2:0] idx_ff, idx_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign rsp_valid = (state_ff == ST_OUT);
   assign out_sel   = idx_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      final_in = final_ff;
      pend_in  = pend_ff;
      tail_in  = tail_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.absorb = req_data.has_byte;
               pend_in    = req_data.is_last;
               final_in   = 1'b0;
               if (req_data.has_byte && stat.fill == 6'd63) begin
                  cmd.round_start = 1'b1;
                  state_in        = ST_LOAD;
               end else if (req_data.is_last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_END: begin
            state_in = ST_PAD;
         end
         ST_PAD: begin
            // a pad byte in the last slot closes the block at once
            cmd.pad_80 = 1'b1;
            pend_in    = 1'b0;
            tail_in    = 1'b1;
            if (stat.fill == 6'd63) begin
               cmd.round_start = 1'b1;
               state_in        = ST_LOAD;
            end else begin
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            // fill up to length field, or close out a block with no room
            if (stat.fill == LenStart && !final_ff) begin
               state_in = ST_LEN;
            end else begin
               cmd.zero_fill = 1'b1;
               if (stat.fill == 6'd63) begin
                  cmd.round_start = 1'b1;
                  state_in        = ST_LOAD;
               end
            end
         end
         ST_LEN: begin
            cmd.len_write = 1'b1;
            if (stat.fill == 6'd63) begin
               final_in        = 1'b1;
               tail_in         = 1'b0;
               cmd.round_start = 1'b1;
               state_in        = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (stat.load_done) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            if (stat.round_last) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.hash_add = 1'b1;
            priority if (final_ff) begin
               idx_in   = 3'd0;
               state_in = ST_OUT;
            end else if (pend_ff) begin
               state_in = ST_END;
            end else if (tail_ff) begin
               state_in = ST_ZERO;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.restart = 1'b1;
                  final_in    = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         final_ff <= 1'b0;
         pend_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         final_ff <= final_in;
         pend_ff  <= pend_in;
         tail_ff  <= tail_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/sha256_hash_engine.sv =====
// A byte that neither fills the block nor ends the message leaves the engine idle.
// A full block is shifted from the buffer RAM into the schedule through its single
// read port, then runs 64 rounds and one hash update.
// End of message: up to 72 padding writes plus one or two blocks, then eight
// digest words at one per cycle while rsp_ready is high.
// Synchronous reset restores the initial hash and empties the buffer.
//------------------------------------------------------------------------------
// SHA-256 hash engine
// Byte-stream SHA-256 with padding and eight-word digest output.
//------------------------------------------------------------------------------
`default_nettype none

module sha256_hash_engine (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire sha256_pkg::req_type req_data,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      sha256_pkg::rsp_type rsp_data
);
   import sha256_pkg::*;

   sha_cmd_type  cmd;
   sha_stat_type stat;
   logic [2:0]   out_sel;
   logic [31:0]  out_word;

   sha256_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .out_sel   (out_sel),
      .stat      (stat),
      .cmd       (cmd)
   );

   sha256_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .in_byte  (req_data.data_byte),
      .out_sel  (out_sel),
      .stat     (stat),
      .out_word (out_word)
   );

   // form the result transaction
   assign rsp_data.digest_word = out_word;
   assign rsp_data.word_index  = out_sel;
   assign rsp_data.last_word   = (out_sel == 3'd7);

endmodule

`default_nettype wire

// ===== src/sha256_checker.sv =====
//------------------------------------------------------------------------------
// SHA-256 port checker
// Watches the ports of the hash engine over time.
//------------------------------------------------------------------------------
`default_nettype none

module sha256_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire sha256_pkg::rsp_type rsp_data
);

   // never take a request while a digest is shown
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("request ready during digest output");

   // word index steps by one after each taken word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_word |=>
      rsp_valid && rsp_data.word_index == $past(rsp_data.word_index) + 3'd1)
      else $error("digest word skipped");

   // after the last word the engine accepts again
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last_word |=> req_ready && !rsp_valid)
      else $error("no return to idle after digest");

   // a stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled digest word changed");

endmodule

bind sha256_hash_engine sha256_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== dv/tb_sha256_hash_engine.sv =====
//------------------------------------------------------------------------------
// SHA-256 hash engine testbench
// Drives byte and end-of-message transactions with random gaps, predicts each
// digest with a behavioral SHA-256 model and checks every digest word in order.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_sha256_hash_engine;
   import sha256_pkg::*;

   localparam int unsigned StallLimit = 20000;
   localparam int unsigned DirRows = 14;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   sha256_hash_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [31:0] hash_state [8];
   logic [7:0]  msg_block [64];
   int unsigned msg_fill;
   logic [63:0] msg_bits;
   rsp_type     digest_queue [$];

   int unsigned mismatch_count = 0;
   int unsigned idle_cycles = 0;
   bit          quiet_sender = 1'b0;
   bit          quiet_receiver = 1'b0;
   bit          rsp_hold = 1'b0;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic restart_hash();
      hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                     32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      foreach (msg_block[i]) msg_block[i] = 8'h00;
      msg_fill = 0;
      msg_bits = '0;
   endtask

   task automatic compress_block();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1, a2, a15;
      int unsigned sl;
      for (int r = 0; r < 16; r++)
         w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
      v = hash_state;
      for (int r = 0; r < 64; r++) begin
         sl = r & 15;
         if (r >= 16) begin
            a2  = w[(sl + 14) & 15];
            a15 = w[(sl + 1) & 15];
            s1 = ror32(a2, 17) ^ ror32(a2, 19) ^ (a2 >> 10);
            s0 = ror32(a15, 7) ^ ror32(a15, 18) ^ (a15 >> 3);
            w[sl] = s1 + w[(sl + 9) & 15] + s0 + w[sl];
         end
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + w[sl];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int r = 0; r < 8; r++) hash_state[r] += v[r];
   endtask

   // absorb one transaction, queue the digest words at end of message
   task automatic absorb_and_digest(input req_type t);
      int unsigned p;
      rsp_type     e;
      if (t.has_byte) begin
         msg_block[msg_fill] = t.data_byte;
         msg_fill++;
         msg_bits += 64'd8;
         if (msg_fill == 64) begin
            compress_block();
            msg_fill = 0;
         end
      end
      if (t.is_last) begin
         p = msg_fill;
         msg_block[p] = PadByte;
         p++;
         if (p > 56) begin
            for (int i = p; i < 64; i++) msg_block[i] = 8'h00;
            compress_block();
            p = 0;
         end
         for (int i = p; i < 56; i++) msg_block[i] = 8'h00;
         for (int k = 0; k < 8; k++) msg_block[56 + k] = msg_bits[63 - 8*k -: 8];
         compress_block();
         for (int k = 0; k < 8; k++) begin
            e.digest_word = hash_state[k];
            e.word_index  = 3'(k);
            e.last_word   = (k == 7);
            digest_queue.push_back(e);
         end
         restart_hash();
      end
   endtask

   // drive one transaction, hold valid until accepted; valid drops only on idling
   task automatic send_item(input req_type t, input bit may_idle);
      while (may_idle && !quiet_sender && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      absorb_and_digest(t);
   endtask

   task automatic drain_digests();
      req_valid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
   endtask

   // directed rows: single bytes, extremes, empty message, idle items
   req_type dir_rows [DirRows] = '{
      '{8'h00, 1'b0, 1'b1},   // empty message right after reset
      '{8'h61, 1'b1, 1'b0}, '{8'h62, 1'b1, 1'b0}, '{8'h63, 1'b1, 1'b1},
      '{8'h5a, 1'b0, 1'b0},   // neither byte nor end
      '{8'hff, 1'b1, 1'b0}, '{8'h00, 1'b1, 1'b0}, '{8'h00, 1'b0, 1'b1},
      '{8'h00, 1'b1, 1'b1}, '{8'hff, 1'b1, 1'b1},
      '{8'ha5, 1'b0, 1'b1}, '{8'h3c, 1'b0, 1'b0}, '{8'hc3, 1'b1, 1'b0},
      '{8'h00, 1'b0, 1'b1}
   };
   // known digest of the empty message, word 0
   localparam logic [31:0] EmptyH0 = 32'he3b0c442;

   task automatic send_message(input int unsigned len, input bit end_with_byte);
      req_type t;
      for (int i = 0; i < len; i++) begin
         t.data_byte = 8'($urandom);
         t.has_byte  = 1'b1;
         t.is_last   = end_with_byte && (i == len - 1);
         if ($urandom_range(15) == 0) begin
            t.has_byte = 1'b0;
            i--;
         end
         send_item(t, 1'b1);
      end
      if (!end_with_byte || len == 0) begin
         t = '{8'($urandom), 1'b0, 1'b1};
         send_item(t, 1'b1);
      end
   endtask

   // response side: random stalls, plus a long hold on request
   always @(posedge clock) begin
      if (reset || rsp_hold)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= quiet_receiver || ($urandom_range(99) >= 28);
   end

   // compare each accepted digest word with the oldest prediction
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected digest word %h idx %0d", rsp_data.digest_word,
                        rsp_data.word_index);
         end else begin
            e = digest_queue.pop_front();
            if (e !== rsp_data) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                           e.digest_word, e.word_index, e.last_word,
                           rsp_data.digest_word, rsp_data.word_index, rsp_data.last_word);
            end
         end
      end
   end

   // watchdog: cycles without any accepted transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int unsigned msg_len;
      restart_hash();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int r = 0; r < DirRows; r++) begin
         send_item(dir_rows[r], 1'b1);
         if (r == 0 && digest_queue.size() == 8 && digest_queue[0].digest_word != EmptyH0) begin
            mismatch_count++;
            $display("empty-message predictor mismatch %h", digest_queue[0].digest_word);
         end
      end
      // boundary lengths around the padding split and block edge
      send_message(55, 1'b1);
      send_message(56, 1'b0);
      send_message(63, 1'b1);
      send_message(64, 1'b0);

      // pause until every digest word has come back
      drain_digests();

      // receiver holds off while messages keep coming
      fork
         begin
            rsp_hold = 1'b1;
            repeat (600) @(posedge clock);
            rsp_hold = 1'b0;
         end
         begin
            send_message(0, 1'b0);
            send_message(3, 1'b1);
            send_message(0, 1'b0);
            send_message(10, 1'b0);
            req_valid <= 1'b0;
         end
      join

      // stretch with no idling on either side
      quiet_sender = 1'b1;
      quiet_receiver = 1'b1;
      send_message(20, 1'b1);
      send_message(9, 1'b0);
      quiet_sender = 1'b0;
      quiet_receiver = 1'b0;

      // two random messages, mostly short (0 to 12 bytes), now and then 60 to 130 bytes
      for (int m = 0; m < 2; m++) begin
         msg_len = ($urandom_range(7) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 12);
         send_message(msg_len, $urandom_range(1));
      end

      drain_digests();
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && digest_queue.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
